### rtl/multi_class_page_allocator_unit_assert.svh
// assertion macros used by the allocator rtl (mcpa_back)
`ifndef MULTI_CLASS_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define MULTI_CLASS_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clock edge outside reset
`define MCPA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("page allocator check failed");
// next-cycle implication
`define MCPA_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("page allocator check failed");
`else
`define MCPA_ASSERT_IMP(label, ante, cons)
`define MCPA_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/mcpa_pkg.sv
package mcpa_pkg;

   // sizes
   localparam int unsigned MAX_PAGES_DEFAULT = 1024;
   localparam int unsigned NUM_CLASSES       = 5;
   localparam int unsigned CLS_W             = 3;
   localparam int unsigned IDX_W             = 10;
   localparam int unsigned CNT_W             = 11;
   localparam int unsigned CSR_IDX_W         = 3;
   localparam int unsigned QUEUE_DEPTH       = 2;

   // request codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // allocation modes
   localparam logic MODE_LIST = 1'b0;
   localparam logic MODE_BUMP = 1'b1;

   // class codes
   localparam logic [CLS_W-1:0] CLASS_BASE = 3'd0;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OOM      = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ALLOC_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X4_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_X2_COUNT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SMALL_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TINY_COUNT  = 3'd5;

   localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;
   localparam logic [CNT_W-1:0] USED_MAX    = '1;

   // classified request handed from front to back
   typedef struct packed {
      logic             func;
      logic             mode;
      logic [CLS_W-1:0] cls;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] count;
   } cmd_type;

endpackage

### rtl/multi_class_page_allocator_unit.sv
// Page allocator with five size classes (base, small x4, small x2, small, tiny).
// Request channel (req_): func 0 allocates a page of page_class, func 1 frees
// page_index of that class. Result channel (rsp_): one result per request with
// status (ok, out of memory, invalid free), the page handed out and the used
// count of the class afterwards. Register port (csr_): index 0 selects list or
// bump mode, indexes 1 to 5 set the page count of each class; always ready.
// A request is taken when valid is high and stall is low on its channel.
// Requests pass through a two-entry queue to the execution stage, which takes
// each request through an issue step and then a finish step: the link memory
// read for a pop is registered before the list head updates. A new request is
// issued only after the previous one has finished. While a result is valid and
// rsp_stall is high the result is held, the finish stage waits, and new
// requests fill the queue until it stalls req_.
// After reset the link memory is initialized one entry per cycle; req_stall
// stays high during that pass while register writes are still taken.
module multi_class_page_allocator_unit #(
   parameter int unsigned MAX_PAGES_PER_CLASS = mcpa_pkg::MAX_PAGES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [mcpa_pkg::CLS_W-1:0]     req_page_class,
   input  logic [mcpa_pkg::IDX_W-1:0]     req_page_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [mcpa_pkg::IDX_W-1:0]     rsp_alloc_index,
   output logic [mcpa_pkg::CNT_W-1:0]     rsp_used_pages,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mcpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mcpa_pkg::CNT_W-1:0]     csr_data
);
   import mcpa_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   logic    init_busy;

   // accept and classify
   mcpa_front #(
      .MAX_PAGES_PER_CLASS (MAX_PAGES_PER_CLASS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_page_class (req_page_class),
      .req_page_index (req_page_index),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .q_full         (full),
      .back_init      (init_busy),
      .q_push         (push),
      .q_cmd          (push_cmd)
   );

   // decoupling queue
   mcpa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head_cmd (head_cmd)
   );

   // list and count execution
   mcpa_back #(
      .MAX_PAGES_PER_CLASS (MAX_PAGES_PER_CLASS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (empty),
      .q_cmd           (head_cmd),
      .q_pop           (pop),
      .init_busy       (init_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_alloc_index (rsp_alloc_index),
      .rsp_used_pages  (rsp_used_pages)
   );

endmodule

### rtl/mcpa_front.sv
module mcpa_front #(
   parameter int unsigned MAX_PAGES_PER_CLASS = mcpa_pkg::MAX_PAGES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [mcpa_pkg::CLS_W-1:0]     req_page_class,
   input  logic [mcpa_pkg::IDX_W-1:0]     req_page_index,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mcpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mcpa_pkg::CNT_W-1:0]     csr_data,
   input  logic                           q_full,
   input  logic                           back_init,
   output logic                           q_push,
   output mcpa_pkg::cmd_type              q_cmd
);
   import mcpa_pkg::*;

   localparam int unsigned CNT_TOP = (2 ** CNT_W) - 1;
   localparam int unsigned CAP_INT =
      (MAX_PAGES_PER_CLASS > CNT_TOP) ? CNT_TOP : MAX_PAGES_PER_CLASS;
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAP_INT);

   logic             mode_ff;
   logic             mode_in;
   logic [CNT_W-1:0] count_ff [NUM_CLASSES];
   logic [CNT_W-1:0] count_in [NUM_CLASSES];
   logic [CLS_W-1:0] cls_sel;
   logic [CNT_W-1:0] raw_count;

   // register writes, always taken
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ALLOC_MODE:  mode_in     = csr_data[0];
            REG_BASE_COUNT:  count_in[0] = csr_data;
            REG_X4_COUNT:    count_in[1] = csr_data;
            REG_X2_COUNT:    count_in[2] = csr_data;
            REG_SMALL_COUNT: count_in[3] = csr_data;
            REG_TINY_COUNT:  count_in[4] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LIST;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            count_ff[i] <= COUNT_RESET;
         end
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   // classify: fold unknown classes onto base, clamp the page count
   assign cls_sel   = (req_page_class >= CLS_W'(NUM_CLASSES)) ? CLASS_BASE : req_page_class;
   assign raw_count = count_ff[cls_sel];

   always_comb begin
      q_cmd.func  = req_func;
      q_cmd.mode  = mode_ff;
      q_cmd.cls   = cls_sel;
      q_cmd.idx   = req_page_index;
      q_cmd.count = (raw_count > CNT_CAP) ? CNT_CAP : raw_count;
   end

   // hold off requests while the queue is full or link memory is initializing
   assign req_stall = q_full || back_init;
   assign q_push    = req_valid && !req_stall;

endmodule

### rtl/mcpa_queue.sv
module mcpa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mcpa_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output mcpa_pkg::cmd_type head_cmd
);
   import mcpa_pkg::*;

   localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   assign full     = (fill_ff == FILL_MAX);
   assign empty    = (fill_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/mcpa_back.sv
`include "multi_class_page_allocator_unit_assert.svh"

module mcpa_back #(
   parameter int unsigned MAX_PAGES_PER_CLASS = mcpa_pkg::MAX_PAGES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  mcpa_pkg::cmd_type          q_cmd,
   output logic                       q_pop,
   output logic                       init_busy,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [mcpa_pkg::IDX_W-1:0] rsp_alloc_index,
   output logic [mcpa_pkg::CNT_W-1:0] rsp_used_pages
);
   import mcpa_pkg::*;

   localparam int unsigned LINK_W = $clog2(MAX_PAGES_PER_CLASS + 1);
   localparam int unsigned PAGE_W = $clog2(MAX_PAGES_PER_CLASS);
   localparam int unsigned DEPTH  = NUM_CLASSES * MAX_PAGES_PER_CLASS;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CMP_W  = (LINK_W > CNT_W) ? LINK_W : CNT_W;
   localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(MAX_PAGES_PER_CLASS - 1);
   localparam logic [CLS_W-1:0]  CLS_LAST  = CLS_W'(NUM_CLASSES - 1);
   localparam logic [ADDR_W-1:0] CLS_SPAN  = ADDR_W'(MAX_PAGES_PER_CLASS);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_ISSUE  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [CLS_W-1:0]  clr_cls_ff;
   logic [CLS_W-1:0]  clr_cls_in;
   logic [PAGE_W-1:0] clr_page_ff;
   logic [PAGE_W-1:0] clr_page_in;
   logic [LINK_W-1:0] head_ff [NUM_CLASSES];
   logic [LINK_W-1:0] head_in [NUM_CLASSES];
   logic [CNT_W-1:0]  used_ff [NUM_CLASSES];
   logic [CNT_W-1:0]  used_in [NUM_CLASSES];
   cmd_type           cmd_ff;
   cmd_type           cmd_in;
   logic [LINK_W-1:0] head_cur_ff;
   logic [LINK_W-1:0] head_cur_in;
   logic [CNT_W-1:0]  used_cur_ff;
   logic [CNT_W-1:0]  used_cur_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [1:0]        rsp_status_in;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [IDX_W-1:0]  rsp_index_in;
   logic [CNT_W-1:0]  rsp_used_ff;
   logic [CNT_W-1:0]  rsp_used_in;

   // link memory
   logic [LINK_W-1:0] link_mem [DEPTH];
   logic [LINK_W-1:0] link_rd_ff;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [LINK_W-1:0] mem_wdata;

   // finish-stage results
   logic [1:0]        fin_status;
   logic [CMP_W-1:0]  fin_given;
   logic [CNT_W-1:0]  fin_used;
   logic [LINK_W-1:0] fin_head;
   logic              fin_push;
   logic [CNT_W-1:0]  used_inc;
   logic              out_free;
   logic [LINK_W-1:0] q_head;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign init_busy = (state_ff == ST_CLEAR);
   assign q_head    = head_ff[q_cmd.cls];

   // carry out the request held in the finish stage
   always_comb begin
      used_inc   = (used_cur_ff == USED_MAX) ? used_cur_ff : used_cur_ff + CNT_W'(1);
      fin_status = STATUS_OK;
      fin_given  = '0;
      fin_used   = used_cur_ff;
      fin_head   = head_cur_ff;
      fin_push   = 1'b0;
      if (cmd_ff.func == FUNC_ALLOC) begin
         if (cmd_ff.mode == MODE_LIST) begin
            if (CMP_W'(head_cur_ff) >= CMP_W'(cmd_ff.count)) begin
               fin_status = STATUS_OOM;
            end else begin
               fin_given = CMP_W'(head_cur_ff);
               fin_head  = link_rd_ff;
               fin_used  = used_inc;
            end
         end else begin
            if (used_cur_ff >= cmd_ff.count) begin
               fin_status = STATUS_OOM;
            end else begin
               fin_given = CMP_W'(used_cur_ff);
               fin_used  = used_cur_ff + CNT_W'(1);
            end
         end
      end else begin
         if ((used_cur_ff == '0) || (CNT_W'(cmd_ff.idx) >= cmd_ff.count)) begin
            fin_status = STATUS_BAD_FREE;
         end else begin
            if (cmd_ff.mode == MODE_LIST) begin
               fin_push = 1'b1;
               fin_head = LINK_W'(cmd_ff.idx);
            end
            fin_used = used_cur_ff - CNT_W'(1);
         end
      end
   end

   // sequencer: clearing pass, then issue / finish per request
   always_comb begin
      state_in      = state_ff;
      clr_cls_in    = clr_cls_ff;
      clr_page_in   = clr_page_ff;
      head_in       = head_ff;
      used_in       = used_ff;
      cmd_in        = cmd_ff;
      head_cur_in   = head_cur_ff;
      used_cur_in   = used_cur_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_used_in   = rsp_used_ff;
      q_pop         = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = ADDR_W'(q_cmd.cls) * CLS_SPAN + ADDR_W'(PAGE_W'(q_head));
      mem_we        = 1'b0;
      mem_waddr     = ADDR_W'(cmd_ff.cls) * CLS_SPAN + ADDR_W'(PAGE_W'(cmd_ff.idx));
      mem_wdata     = head_cur_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(clr_cls_ff) * CLS_SPAN + ADDR_W'(clr_page_ff);
            mem_wdata = LINK_W'(clr_page_ff) + LINK_W'(1);
            if (clr_page_ff == PAGE_LAST) begin
               clr_page_in = '0;
               if (clr_cls_ff == CLS_LAST) begin
                  state_in = ST_ISSUE;
               end else begin
                  clr_cls_in = clr_cls_ff + CLS_W'(1);
               end
            end else begin
               clr_page_in = clr_page_ff + PAGE_W'(1);
            end
         end
         ST_ISSUE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               mem_re      = 1'b1;
               cmd_in      = q_cmd;
               head_cur_in = q_head;
               used_cur_in = used_ff[q_cmd.cls];
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               mem_we                = fin_push;
               head_in[cmd_ff.cls]   = fin_head;
               used_in[cmd_ff.cls]   = fin_used;
               rsp_valid_in          = 1'b1;
               rsp_status_in         = fin_status;
               rsp_index_in          = IDX_W'(fin_given);
               rsp_used_in           = fin_used;
               state_in              = ST_ISSUE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cls_ff   <= '0;
         clr_page_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= '0;
            used_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_cls_ff   <= clr_cls_in;
         clr_page_ff  <= clr_page_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         used_ff      <= used_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      head_cur_ff   <= head_cur_in;
      used_cur_ff   <= used_cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // link memory write port and registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         link_rd_ff <= link_mem[mem_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_alloc_index = rsp_index_ff;
   assign rsp_used_pages  = rsp_used_ff;

   // checks
   `MCPA_ASSERT_IMP(a_no_pop_in_clear, state_ff == ST_CLEAR, !q_pop)
   `MCPA_ASSERT_NXT(a_pop_enters_finish, q_pop, state_ff == ST_FINISH)
   `MCPA_ASSERT_IMP(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH))
   `MCPA_ASSERT_IMP(a_link_held, (state_ff == ST_FINISH) && $past(state_ff == ST_FINISH), $stable(link_rd_ff))

endmodule
